FILE: rtl/core/sfd_pkg.sv
// Shared constants, register codes and lane control type of the stereo feedback delay.
`default_nettype none

package sfd_pkg;

  // Default store depth and sample width (store depth must be a power of two)
  localparam int unsigned STORE_DEPTH = 262144;
  localparam int unsigned SAMPLE_BITS = 24;

  // Configuration register widths
  localparam int unsigned DELAY_W    = 18;
  localparam int unsigned FB_GAIN_W  = 15;
  localparam int unsigned LVL_GAIN_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // Register reset values
  localparam logic [DELAY_W-1:0]    DELAY_RST    = 18'd38400;
  localparam logic [FB_GAIN_W-1:0]  FB_GAIN_RST  = 15'd11627;
  localparam logic [LVL_GAIN_W-1:0] LVL_GAIN_RST = 16'd4125;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_FB_GAIN  = 2'd1,
    REG_LVL_GAIN = 2'd2
  } cfg_reg_e;

  // Per-word control handed from the sequencer to each lane
  typedef struct packed {
    logic rd_en;    // word accepted: issue store read, latch input sample
    logic fill_ok;  // read entry has been written since reset
    logic fwd_hit;  // read entry is the one written at this same edge
    logic wr_en;    // word in compute stage advances: write feedback sample
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfd_lane.sv
// One channel lane: ring store, registered read with forwarding, gain, round and saturate.
`default_nettype none

module sfd_lane #(
  parameter int unsigned SB = sfd_pkg::SAMPLE_BITS,
  parameter int unsigned AW = $clog2(sfd_pkg::STORE_DEPTH)
) (
  input  wire  logic                             clk_i,
  input  wire  logic                             rst_ni,
  input  wire  sfd_pkg::lane_ctrl_t              ctrl_i,
  input  wire  logic [AW-1:0]                    rd_addr_i,
  input  wire  logic [AW-1:0]                    wr_addr_i,
  input  wire  logic signed [SB-1:0]             sample_i,
  input  wire  logic [sfd_pkg::FB_GAIN_W-1:0]    fb_gain_i,
  input  wire  logic [sfd_pkg::LVL_GAIN_W-1:0]   lvl_gain_i,
  output logic signed [SB-1:0]                   sample_o
);

  localparam int unsigned PW = SB + 17;

  logic signed [SB-1:0] mem [2**AW];
  logic signed [SB-1:0] rdata_q;
  logic signed [SB-1:0] fwd_data_q;
  logic signed [SB-1:0] in_q;
  logic                 fill_ok_q;
  logic                 fwd_q;

  logic signed [SB-1:0] delayed;
  logic signed [SB-1:0] fed;
  logic signed [PW-1:0] prod_fb;
  logic signed [PW-1:0] prod_lvl;
  logic signed [16:0]   fb_gain_s;
  logic signed [16:0]   lvl_gain_s;

  // Scale a Q1.15 product with round half up, add the dry sample, saturate
  function automatic logic signed [SB-1:0] mix(input logic signed [SB-1:0] x,
                                               input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    logic signed [SB+2:0] s;
    r = (p + PW'(16384)) >>> 15;
    s = (SB+3)'(x) + (SB+3)'(r);
    if (s[SB+2:SB-1] == '0 || s[SB+2:SB-1] == '1) begin
      mix = s[SB-1:0];
    end else if (s[SB+2]) begin
      mix = {1'b1, {(SB-1){1'b0}}};
    end else begin
      mix = {1'b0, {(SB-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= fed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Hold sample and the feedback word being written, for forwarding
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      in_q       <= sample_i;
      fwd_data_q <= fed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_ok_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      fill_ok_q <= ctrl_i.fill_ok;
      fwd_q     <= ctrl_i.fwd_hit;
    end
  end

  always_comb begin
    if (fwd_q) begin
      delayed = fwd_data_q;
    end else if (fill_ok_q) begin
      delayed = rdata_q;
    end else begin
      delayed = '0;
    end
  end

  assign fb_gain_s  = $signed({2'b00, fb_gain_i});
  assign lvl_gain_s = $signed({1'b0, lvl_gain_i});
  assign prod_fb    = PW'(delayed) * PW'(fb_gain_s);
  assign prod_lvl   = PW'(delayed) * PW'(lvl_gain_s);

  assign fed      = mix(in_q, prod_fb);
  assign sample_o = mix(in_q, prod_lvl);

endmodule

`default_nettype wire

FILE: rtl/core/stereo_feedback_delay_top.sv
// Top level of the stereo feedback delay: config registers, ring pointer, two lanes, output register.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+----------------------------------
//   in      | in  | in_valid_i / in_stall_o    | left_in_i, right_in_i
//   out     | out | out_valid_o / out_stall_i  | left_out_o, right_out_o
//   cfg     | in  | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One word per cycle unless the output stalls; results pass the compute stage and output register.
// The rate is set by the single read and single write port of each channel store.
// A delay of one sample closes the loop read, multiply, round, add, saturate combinationally in the compute stage.
// Reset clears pointer and fill flag; entries not yet written since reset read as zero,
// so no clearing pass is needed and words are accepted from the first cycle after reset.
// in_stall_o rises only while the compute stage is full and the output word is stalled.
`default_nettype none

module stereo_feedback_delay_top #(
  parameter int unsigned STORE_DEPTH = sfd_pkg::STORE_DEPTH,
  parameter int unsigned SAMPLE_BITS = sfd_pkg::SAMPLE_BITS
) (
  input  wire  logic                              clk_i,
  input  wire  logic                              rst_ni,
  // input words
  input  wire  logic                              in_valid_i,
  output logic                                    in_stall_o,
  input  wire  logic signed [SAMPLE_BITS-1:0]     left_in_i,
  input  wire  logic signed [SAMPLE_BITS-1:0]     right_in_i,
  // output words
  output logic                                    out_valid_o,
  input  wire  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]           left_out_o,
  output logic signed [SAMPLE_BITS-1:0]           right_out_o,
  // configuration writes
  input  wire  logic                              cfg_we_i,
  input  wire  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  // Ring index width; the store depth is a power of two so the index wraps naturally
  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic [sfd_pkg::DELAY_W-1:0]    delay_q;
  logic [sfd_pkg::FB_GAIN_W-1:0]  fb_gain_q;
  logic [sfd_pkg::LVL_GAIN_W-1:0] lvl_gain_q;

  logic [AW-1:0] wr_q;       // ring position of the next accepted word
  logic          full_q;     // ring has wrapped once: every entry written
  logic          s1_valid_q; // compute stage holds a word
  logic [AW-1:0] s1_wr_q;    // ring position of that word
  logic          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] left_out_q;
  logic signed [SAMPLE_BITS-1:0] right_out_q;

  logic          out_adv;
  logic          s1_adv;
  logic          in_acc;
  logic [AW-1:0] dly;
  logic [AW-1:0] rd_addr;
  sfd_pkg::lane_ctrl_t lane_ctrl;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= sfd_pkg::DELAY_RST;
      fb_gain_q  <= sfd_pkg::FB_GAIN_RST;
      lvl_gain_q <= sfd_pkg::LVL_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfd_pkg::REG_DELAY:    delay_q    <= cfg_wdata_i[sfd_pkg::DELAY_W-1:0];
        sfd_pkg::REG_FB_GAIN:  fb_gain_q  <= cfg_wdata_i[sfd_pkg::FB_GAIN_W-1:0];
        sfd_pkg::REG_LVL_GAIN: lvl_gain_q <= cfg_wdata_i[sfd_pkg::LVL_GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: output register frees, compute stage advances, input accepted
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Delay modulo the depth, then read position behind the write position
  assign dly     = AW'(delay_q);
  assign rd_addr = wr_q - dly;

  // The word in the compute stage writes at the same edge this read happens:
  // forward its feedback sample when it targets the read entry.
  always_comb begin
    lane_ctrl.rd_en   = in_acc;
    lane_ctrl.fill_ok = full_q || (rd_addr < wr_q);
    lane_ctrl.fwd_hit = s1_adv && (s1_wr_q == rd_addr);
    lane_ctrl.wr_en   = s1_adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q       <= '0;
      full_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        wr_q <= wr_q + AW'(1);
        if (wr_q == '1) begin
          full_q <= 1'b1;
        end
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_wr_q <= wr_q;
    end
  end

  sfd_lane #(
    .SB (SAMPLE_BITS),
    .AW (AW)
  ) u_lane_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (s1_wr_q),
    .sample_i   (left_in_i),
    .fb_gain_i  (fb_gain_q),
    .lvl_gain_i (lvl_gain_q),
    .sample_o   (left_res)
  );

  sfd_lane #(
    .SB (SAMPLE_BITS),
    .AW (AW)
  ) u_lane_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (s1_wr_q),
    .sample_i   (right_in_i),
    .fb_gain_i  (fb_gain_q),
    .lvl_gain_i (lvl_gain_q),
    .sample_o   (right_res)
  );

  // Merge both lanes into one output word; hold it while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_out_q  <= left_res;
      right_out_q <= right_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

  // Stall only with a word waiting in the compute stage
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty compute stage");

  // Ring position advances by exactly one per accepted word
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (wr_q == $past(wr_q) + AW'(1)))
    else $error("ring position did not advance by one");

  // Once wrapped, the ring stays marked as fully written
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("fill flag dropped");

  // A blocked compute stage keeps its word and ring position
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_adv) |=> (s1_valid_q && $stable(s1_wr_q)))
    else $error("compute stage lost its word while blocked");

endmodule

`default_nettype wire

FILE: test/tb_stereo_feedback_delay_top.sv
// Self-checking testbench of the stereo feedback delay: directed table, then random phases.
module tb_stereo_feedback_delay_top;
  import sfd_pkg::*;

  localparam int unsigned SB          = SAMPLE_BITS;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned LIMIT       = 200000;  // cycles before the run is declared hung
  localparam int unsigned HOLD_CYCLES = 200;     // long receiver hold-off in the pressure phase
  localparam int unsigned N_PHASE     = 9;
  localparam int unsigned PHASE_WORDS = 160;
  localparam int unsigned N_DIR       = 24;
  localparam int unsigned TAIL_CYCLES = 8;       // tail watched for stray output words after the drain

  // Index past the register list; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic signed [SB-1:0] sample_t;

  localparam sample_t S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SB-1){1'b0}}};

  // Echo delay per random phase; zero and the largest value read never-written entries
  localparam int unsigned DLY_TAB [N_PHASE] = '{1, 3, 2, 0, 7, 262143, 40, 5, 1};

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   wdata;
    sample_t                 left;
    sample_t                 right;
    logic                    lit;        // expected word typed in below
    sample_t                 exp_left;
    sample_t                 exp_right;
  } dir_row_t;

  // Directed stimulus; rows with lit set carry their expected word, the rest use the predictor
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // empty stores after reset: output equals input
    '{ROW_WORD, 2'd0, 18'd0, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
    '{ROW_WORD, 2'd0, 18'd0, '0, '0, 1'b1, '0, '0},
    '{ROW_WORD, 2'd0, 18'd0, sample_t'(-1), sample_t'(1), 1'b1, sample_t'(-1), sample_t'(1)},
    // one-sample loop at full feedback and unity level
    '{ROW_REG, REG_DELAY, 18'd1, '0, '0, 1'b0, '0, '0},
    '{ROW_REG, REG_FB_GAIN, 18'd32767, '0, '0, 1'b0, '0, '0},
    '{ROW_REG, REG_LVL_GAIN, 18'd32768, '0, '0, 1'b0, '0, '0},
    '{ROW_WORD, 2'd0, 18'd0, S_MAX, S_MIN, 1'b0, '0, '0},
    // dry plus echo overflows both ways: saturate
    '{ROW_WORD, 2'd0, 18'd0, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
    // all ones on the port: upper bits dropped, level gain above one
    '{ROW_REG, REG_FB_GAIN, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_REG, REG_LVL_GAIN, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WORD, 2'd0, 18'd0, S_MIN, S_MAX, 1'b0, '0, '0},
    '{ROW_WORD, 2'd0, 18'd0, sample_t'(4000000), sample_t'(-4000000), 1'b0, '0, '0},
    '{ROW_WORD, 2'd0, 18'd0, '0, '0, 1'b0, '0, '0},
    // zero delay reads the entry about to be overwritten, never written yet
    '{ROW_REG, REG_DELAY, 18'd0, '0, '0, 1'b0, '0, '0},
    '{ROW_WORD, 2'd0, 18'd0, sample_t'(123456), sample_t'(-654321), 1'b1,
      sample_t'(123456), sample_t'(-654321)},
    // largest delay reads one ahead of the write pointer, never written yet
    '{ROW_REG, REG_DELAY, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WORD, 2'd0, 18'd0, sample_t'(-777), sample_t'(777), 1'b1,
      sample_t'(-777), sample_t'(777)},
    // zero gains: dry path only
    '{ROW_REG, REG_FB_GAIN, 18'd0, '0, '0, 1'b0, '0, '0},
    '{ROW_REG, REG_LVL_GAIN, 18'd0, '0, '0, 1'b0, '0, '0},
    '{ROW_REG, REG_DELAY, 18'd2, '0, '0, 1'b0, '0, '0},
    '{ROW_WORD, 2'd0, 18'd0, sample_t'(5555), sample_t'(-5555), 1'b1,
      sample_t'(5555), sample_t'(-5555)},
    '{ROW_WORD, 2'd0, 18'd0, S_MIN, S_MAX, 1'b1, S_MIN, S_MAX},
    // write to an index past the list: no effect
    '{ROW_REG, REG_UNUSED, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WORD, 2'd0, 18'd0, sample_t'(1000), sample_t'(-1000), 1'b0, '0, '0}
  };

  // DUT connections; every input starts at a known value
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  sample_t               left_in   = '0;
  sample_t               right_in  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sample_t               left_out;
  sample_t               right_out;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  stereo_feedback_delay_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .left_in_i   (left_in),
    .right_in_i  (right_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .left_out_o  (left_out),
    .right_out_o (right_out),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  // Echo predictor state: its own ring stores, pointer and register copies
  bit signed [SB-1:0]    echo_mem_l [STORE_DEPTH];
  bit signed [SB-1:0]    echo_mem_r [STORE_DEPTH];
  bit [AW-1:0]           mdl_wr_pos = '0;
  bit [DELAY_W-1:0]      mdl_delay  = DELAY_RST;
  bit [FB_GAIN_W-1:0]    mdl_fb     = FB_GAIN_RST;
  bit [LVL_GAIN_W-1:0]   mdl_lvl    = LVL_GAIN_RST;

  frame_t                pending_out [$];  // expected output words, oldest first
  int unsigned           n_err = 0;
  int unsigned           cycle_cnt = 0;
  int unsigned           src_idle_pct = 0;
  int unsigned           snk_stall_pct = 0;
  bit                    hold_armed = 1'b0;
  bit                    sink_hold = 1'b0;

  // dry + round_half_up(echo * gain / 2^15), saturated to the sample width
  function automatic sample_t add_scaled(sample_t dry, sample_t echo,
                                         logic [LVL_GAIN_W-1:0] gain);
    longint prod;
    longint sum;
    prod = (longint'(echo) * longint'($signed({1'b0, gain})) + 64'sd16384) >>> 15;
    sum  = longint'(dry) + prod;
    if (sum > longint'(S_MAX)) return S_MAX;
    if (sum < longint'(S_MIN)) return S_MIN;
    return sample_t'(sum);
  endfunction

  // Advance the predictor by one stereo word: read the tap, write the feedback, bump the pointer
  function automatic frame_t echo_step(sample_t l, sample_t r);
    bit [AW-1:0] rd;
    sample_t     dl;
    sample_t     dr;
    frame_t      res;
    rd = mdl_wr_pos - AW'(mdl_delay);
    dl = echo_mem_l[rd];
    dr = echo_mem_r[rd];
    echo_mem_l[mdl_wr_pos] = add_scaled(l, dl, mdl_fb);
    echo_mem_r[mdl_wr_pos] = add_scaled(r, dr, mdl_fb);
    res.left   = add_scaled(l, dl, mdl_lvl);
    res.right  = add_scaled(r, dr, mdl_lvl);
    mdl_wr_pos = mdl_wr_pos + 1'b1;
    return res;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9, 0))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'(int'($urandom_range(511, 0)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Write one register and mirror it; leave the enable high, the next word lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_DELAY:    mdl_delay = data[DELAY_W-1:0];
      REG_FB_GAIN:  mdl_fb    = data[FB_GAIN_W-1:0];
      REG_LVL_GAIN: mdl_lvl   = data[LVL_GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offer one word, idle first at the current rate, hold it until accepted.
  // Valid stays high on return so back-to-back words need no gap.
  task automatic offer_frame(sample_t l, sample_t r, logic lit, sample_t lit_l, sample_t lit_r);
    bit     taken;
    frame_t exp_f;
    cfg_we <= 1'b0;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    taken = 1'b0;
    // stall is stable mid-cycle; sample it there, accept at the next edge
    while (!taken) begin
      @(negedge clk_i);
      taken = (in_stall === 1'b0);
      @(posedge clk_i);
    end
    exp_f = echo_step(l, r);
    if (lit) begin
      exp_f.left  = lit_l;
      exp_f.right = lit_r;
    end
    pending_out.push_back(exp_f);
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall at the phase rate, forced high during the long hold-off
  always @(posedge clk_i) begin
    out_stall <= sink_hold || ($urandom_range(99, 0) < snk_stall_pct);
  end

  // Long hold-off, counted here so the sender keeps pushing and the block backs up
  initial begin
    wait (hold_armed);
    @(negedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    sink_hold = 1'b0;
  end

  // Check each output word taken at the coming edge against the oldest expectation
  always @(negedge clk_i) begin
    frame_t want;
    if (rst_ni && out_valid === 1'b1 && !out_stall) begin
      if (pending_out.size() == 0) begin
        $error("unexpected output word: left_out %0d right_out %0d", left_out, right_out);
        n_err++;
      end else begin
        want = pending_out.pop_front();
        if (left_out !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, left_out);
          n_err++;
        end
        if (right_out !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, right_out);
          n_err++;
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] wd;
    int unsigned           fb;
    int unsigned           lvl;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, light idling on both sides
    src_idle_pct  = 6;
    snk_stall_pct = 6;
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_REG) begin
        drain();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].wdata);
      end else begin
        offer_frame(DIR_TAB[i].left, DIR_TAB[i].right, DIR_TAB[i].lit,
                    DIR_TAB[i].exp_left, DIR_TAB[i].exp_right);
      end
    end

    // Random phases: new settings while idle, then a run of words
    for (int ph = 0; ph < N_PHASE; ph++) begin
      drain();
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
        default: begin src_idle_pct = 6; snk_stall_pct = 6; end
      endcase
      // last phase: full rate into a long receiver hold-off
      if (ph == N_PHASE - 1) begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end

      fb  = (ph == 0) ? 32767 : (ph == 1) ? 0 : $urandom_range(32767, 0);
      lvl = (ph == 2) ? 32768 : (ph == 3) ? 0 : (ph == 4) ? 65535 :
            (ph == 6) ? 32767 : $urandom_range(32768, 0);

      write_reg(REG_DELAY, CFG_DATA_W'(DLY_TAB[ph]));
      // random upper bits on the port; the block keeps only the register's width
      wd = CFG_DATA_W'($urandom);
      wd[FB_GAIN_W-1:0] = FB_GAIN_W'(fb);
      write_reg(REG_FB_GAIN, wd);
      wd = CFG_DATA_W'($urandom);
      wd[LVL_GAIN_W-1:0] = LVL_GAIN_W'(lvl);
      write_reg(REG_LVL_GAIN, wd);
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

      if (ph == N_PHASE - 1) hold_armed = 1'b1;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        offer_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
      end
    end

    // Let every result out, then watch the tail for strays
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_err == 0 && pending_out.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
